@@ hw/rtl/midi_note_gate_top_macros.svh @@
// Assertion macros for the checker file of the note gate.
// Both sample on clk_i and are switched off while rst_ni is low.
`ifndef MIDI_NOTE_GATE_TOP_MACROS_SVH
`define MIDI_NOTE_GATE_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MNG_ASSERT_SAME(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("note gate check failed");

// The consequent must hold in the cycle after the antecedent.
`define MNG_ASSERT_NEXT(label, pre, post) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("note gate check failed");

`endif

@@ hw/rtl/mng_pkg.sv @@
`default_nettype none
package mng_pkg;

  localparam int unsigned IDX_W      = 11;
  localparam int unsigned TABLE_DEPTH = 2048;
  localparam int unsigned VEL_W      = 7;
  localparam int unsigned REG_W      = 31;
  localparam int unsigned COUNT_W    = 12;
  localparam int unsigned MSG_W      = 24;
  localparam int unsigned EV_W       = 3;

  // Input word kinds.
  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_NOTE    = 2'd1;
  localparam logic [1:0] KIND_PROGRAM = 2'd2;

  // Result codes.
  localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EV_W-1:0] EV_NOTE_ON  = 3'd1;
  localparam logic [EV_W-1:0] EV_NOTE_OFF = 3'd2;
  localparam logic [EV_W-1:0] EV_PROGRAM  = 3'd3;
  localparam logic [EV_W-1:0] EV_CLEARED  = 3'd4;
  localparam logic [EV_W-1:0] EV_ABORTED  = 3'd5;

  // MIDI command nibbles.
  localparam logic [3:0] CMD_NOTE_OFF = 4'd8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'd9;
  localparam logic [3:0] CMD_PROGRAM  = 4'd12;

  // Configuration register indexes.
  localparam logic REG_BURN_IN = 1'b0;
  localparam logic REG_HOLD    = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/mng_ram.sv @@
`default_nettype none
module mng_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

@@ hw/rtl/midi_note_gate_top.sv @@
// Each input word is taken while its table entry is read; the entry is then changed as needed
// and written back as the result is registered, which waits while the result register is full.
// A new input word is taken only once the last one is in the result register and no pass runs.
// Reset: asynchronous, active low; then a clearing pass zeroes all 2048 table words. Each "table
// cleared" or "others aborted" result starts that pass again; an abort keeps its own note's entry.
`default_nettype none
module midi_note_gate_top
  import mng_pkg::*;
#(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Input stream.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // Fields from bit 0 up: channel[3:0], key[10:4], velocity[17:11], program_req[24:18].
  input  wire logic [31:0] s_axis_tdata,
  // Fields from bit 0 up: kind[1:0].
  input  wire logic [1:0]  s_axis_tuser,
  // Result stream.
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // Fields from bit 0 up: message[23:0].
  output logic [23:0]      m_axis_tdata,
  // Fields from bit 0 up: event_res[2:0].
  output logic [2:0]       m_axis_tuser,
  // Configuration port.
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  // Each table word holds, from the top: valid, running, velocity, start time.
  localparam int unsigned ENT_W = TIME_WIDTH + VEL_W + 2;
  // Width at which elapsed time and the tick registers are compared.
  localparam int unsigned CMP_W = (TIME_WIDTH > REG_W) ? TIME_WIDTH : REG_W;

  localparam logic [1:0] ST_SWEEP = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;

  logic [1:0] state_q, state_d;

  // Configuration registers. Writes land whenever the access phase completes.
  logic [REG_W-1:0] burn_q, hold_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_HOLD) ? {1'b0, hold_q} : {1'b0, burn_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burn_q <= REG_W'(1000);
      hold_q <= REG_W'(2000000);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_HOLD) begin
        hold_q <= pwdata[REG_W-1:0];
      end else begin
        burn_q <= pwdata[REG_W-1:0];
      end
    end
  end

  // The accepted word is held here while its table entry is read.
  logic [1:0]       kind_q;
  logic [3:0]       ch_q;
  logic [6:0]       key_q;
  logic [VEL_W-1:0] vel_q;
  logic [6:0]       prog_q;
  logic             in_acc;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      kind_q <= s_axis_tuser;
      ch_q   <= s_axis_tdata[3:0];
      key_q  <= s_axis_tdata[10:4];
      vel_q  <= s_axis_tdata[17:11];
      prog_q <= s_axis_tdata[24:18];
    end
  end

  // Note table: one word per channel and key.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic [ENT_W-1:0] ram_rdata;

  mng_ram #(
    .WIDTH(ENT_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (in_acc),
    .raddr_i({s_axis_tdata[3:0], s_axis_tdata[10:4]}),
    .rdata_o(ram_rdata)
  );

  logic                  ent_valid, ent_run;
  logic [VEL_W-1:0]      ent_vel;
  logic [TIME_WIDTH-1:0] ent_start, elapsed;
  logic                  before_burn, past_hold;
  logic [IDX_W-1:0]      idx;

  assign ent_valid   = ram_rdata[ENT_W-1];
  assign ent_run     = ram_rdata[ENT_W-2];
  assign ent_vel     = ram_rdata[TIME_WIDTH +: VEL_W];
  assign ent_start   = ram_rdata[TIME_WIDTH-1:0];
  assign idx         = {ch_q, key_q};

  // Elapsed time wraps with the tick counter.
  logic [TIME_WIDTH-1:0] time_q, time_d;
  logic [COUNT_W-1:0]    count_q, count_d;

  assign elapsed     = time_q - ent_start;
  assign before_burn = CMP_W'(elapsed) < CMP_W'(burn_q);
  assign past_hold   = CMP_W'(elapsed) >= CMP_W'(hold_q);

  // Result register: the input side may take a new word while it waits.
  logic             out_valid_q;
  logic [EV_W-1:0]  ev_q, ev_d;
  logic [MSG_W-1:0] msg_q, msg_d;
  logic             slot_free, out_load;

  assign slot_free = !out_valid_q || m_axis_tready;
  assign out_load  = (state_q == ST_EXEC) && slot_free;

  // Sweep control: the entry of an aborting note survives the pass.
  logic [IDX_W-1:0] sweep_q, sweep_d;
  logic             keep_q, keep_d;
  logic             go_sweep;
  logic             exec_we;
  logic [ENT_W-1:0] exec_wdata;

  always_comb begin
    ev_d       = EV_NONE;
    msg_d      = '0;
    time_d     = time_q;
    count_d    = count_q;
    exec_we    = 1'b0;
    exec_wdata = '0;
    go_sweep   = 1'b0;
    keep_d     = keep_q;
    case (kind_q)
      KIND_TICK: begin
        time_d = time_q + TIME_WIDTH'(1);
      end
      KIND_PROGRAM: begin
        ev_d  = EV_PROGRAM;
        msg_d = {8'd0, 1'b0, prog_q, CMD_PROGRAM, ch_q};
      end
      KIND_NOTE: begin
        if (!ent_valid) begin
          if (vel_q != '0) begin
            exec_we    = 1'b1;
            exec_wdata = {1'b1, 1'b0, vel_q, time_q};
            count_d    = count_q + COUNT_W'(1);
          end
        end else if (!ent_run) begin
          if (before_burn) begin
            // Still collecting: keep the strongest strike.
            if (vel_q > ent_vel) begin
              exec_we    = 1'b1;
              exec_wdata = {1'b1, 1'b0, vel_q, ent_start};
            end
          end else begin
            ev_d       = EV_NOTE_ON;
            msg_d      = {1'b0, ent_vel, 1'b0, key_q, CMD_NOTE_ON, ch_q};
            exec_we    = 1'b1;
            exec_wdata = {1'b1, 1'b1, ent_vel, ent_start};
          end
        end else if (vel_q == '0) begin
          ev_d     = EV_CLEARED;
          count_d  = '0;
          go_sweep = 1'b1;
          keep_d   = 1'b0;
        end else if (count_q > COUNT_W'(1)) begin
          ev_d     = EV_ABORTED;
          count_d  = COUNT_W'(1);
          go_sweep = 1'b1;
          keep_d   = 1'b1;
        end else if (past_hold) begin
          ev_d       = EV_NOTE_OFF;
          msg_d      = {1'b0, vel_q, 1'b0, key_q, CMD_NOTE_OFF, ch_q};
          exec_we    = 1'b1;
          exec_wdata = '0;
          count_d    = count_q - COUNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  // Table write port: the sweep owns it while it runs.
  always_comb begin
    if (state_q == ST_SWEEP) begin
      ram_we    = !(keep_q && (sweep_q == idx));
      ram_waddr = sweep_q;
      ram_wdata = '0;
    end else begin
      ram_we    = out_load && exec_we;
      ram_waddr = idx;
      ram_wdata = exec_wdata;
    end
  end

  always_comb begin
    state_d = state_q;
    sweep_d = sweep_q;
    case (state_q)
      ST_SWEEP: begin
        sweep_d = sweep_q + IDX_W'(1);
        if (sweep_q == IDX_W'(TABLE_DEPTH - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_d = go_sweep ? ST_SWEEP : ST_IDLE;
          sweep_d = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_SWEEP;
      sweep_q     <= '0;
      keep_q      <= 1'b0;
      time_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      if (out_load) begin
        keep_q      <= keep_d;
        time_q      <= time_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      ev_q  <= ev_d;
      msg_q <= msg_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = msg_q;
  assign m_axis_tuser  = ev_q;

endmodule
`default_nettype wire

@@ hw/rtl/mng_checker.sv @@
`default_nettype none
`include "midi_note_gate_top_macros.svh"
module mng_checker
  import mng_pkg::*;
(
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic [2:0]  m_axis_tuser
);

  // A stalled result word holds.
  `MNG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

  // One word at a time: the input side closes right after an accept.
  `MNG_ASSERT_NEXT(a_one_at_a_time, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // Results that send nothing carry an empty message.
  `MNG_ASSERT_SAME(a_empty_msg, m_axis_tvalid && (m_axis_tuser == EV_NONE ||
    m_axis_tuser == EV_CLEARED || m_axis_tuser == EV_ABORTED), m_axis_tdata == '0)

  // A program result carries the program change command.
  `MNG_ASSERT_SAME(a_prog_cmd, m_axis_tvalid && (m_axis_tuser == EV_PROGRAM),
    m_axis_tdata[7:4] == CMD_PROGRAM)

endmodule

bind midi_note_gate_top mng_checker u_mng_checker (.*);
`default_nettype wire
